[hdl/sakvc_pkg.sv]
// Package for the set-associative keyed value cache.
// Holds payload structs, opcodes, sizing constants and the front-to-back command type.
// No dependencies.
package sakvc_pkg;

  localparam int unsigned DefWays     = 4;
  localparam int unsigned DefSets     = 127;
  localparam int unsigned DefKeyWidth = 32;
  localparam int unsigned HoldW       = 16;
  localparam logic [HoldW-1:0] HoldMax = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_STORE  = 2'd1,
    OP_INVAL  = 2'd2,
    OP_WINDOW = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_MISS    = 2'd1,
    ST_NOCACHE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] object_id;
    logic [31:0] property_key;
    logic [31:0] store_value;
    logic [7:0]  pending_invals;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_EXEC,
    BK_SWEEP,
    BK_SWEEP_WAIT,
    BK_CLEAR,
    BK_OUT
  } bk_state_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_HASH,
    FR_SUM,
    FR_MOD,
    FR_PUSH
  } fr_state_t;

endpackage

[hdl/sakvc_front.sv]
// Front end of the keyed value cache: accepts items and computes the set index.
// Depends on sakvc_pkg. The hash is reduced mod SETS by summing per-bit residues
// and then trimming the sum with compare and subtract steps.
module sakvc_front #(
  parameter int unsigned SETS = sakvc_pkg::DefSets,
  parameter int unsigned KEY_WIDTH = sakvc_pkg::DefKeyWidth,
  parameter int unsigned SET_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  sakvc_pkg::in_item_t in_item,
  input  logic                in_valid,
  output logic                in_ready,
  output sakvc_pkg::in_item_t cmd_item,
  output logic [SET_W-1:0]    cmd_set,
  output logic                cmd_valid,
  input  logic                cmd_ready
);
  import sakvc_pkg::*;

  // The shifted id keeps 36 bits; the shifted key never reaches past them
  localparam int unsigned HW = 36;
  localparam int unsigned GB = 9;
  localparam int unsigned NG = HW / GB;
  localparam int unsigned PW = SET_W + 4;
  localparam int unsigned AW = SET_W + 6;

  // Residue of 2^i mod SETS for every hash bit, packed SET_W bits apiece
  function automatic logic [HW*SET_W-1:0] res_table();
    logic [HW*SET_W-1:0] t;
    int unsigned r;
    t = '0;
    r = 1 % SETS;
    for (int i = 0; i < HW; i++) begin
      t[i*SET_W +: SET_W] = SET_W'(r);
      r = (r * 2) % SETS;
    end
    return t;
  endfunction

  localparam logic [HW*SET_W-1:0] RES = res_table();

  fr_state_t      state, state_next;
  in_item_t       item, in_m;
  logic [HW-1:0]  hash;
  logic [PW-1:0]  psum [NG];
  logic [PW-1:0]  psum_next [NG];
  logic [AW-1:0]  acc, tot, red;
  logic [SET_W-1:0] rem;
  logic [KEY_WIDTH-1:0] key_m;
  logic [HW-1:0]  id_sh, key_sh;

  // Mask key to KEY_WIDTH and build the unreduced hash
  always_comb begin
    key_m  = KEY_WIDTH'({32'd0, in_item.property_key});
    in_m   = in_item;
    in_m.property_key = 32'(key_m);
    id_sh  = HW'({in_item.object_id, 4'd0});
    key_sh = HW'(key_m >> 3);
  end

  // Sum the residues of the set bits, one group of bits per partial sum
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      psum_next[g] = '0;
      for (int b = 0; b < GB; b++) begin
        if (hash[g*GB+b]) psum_next[g] = psum_next[g] + PW'(RES[(g*GB+b)*SET_W +: SET_W]);
      end
    end
  end

  // Add the partial sums and take off 32, 16 and 8 times SETS where they fit
  always_comb begin
    tot = '0;
    for (int g = 0; g < NG; g++) tot = tot + AW'(psum[g]);
    if (tot >= AW'(32 * SETS)) tot = tot - AW'(32 * SETS);
    if (tot >= AW'(16 * SETS)) tot = tot - AW'(16 * SETS);
    if (tot >= AW'(8 * SETS))  tot = tot - AW'(8 * SETS);
  end

  // Finish with 4, 2 and 1 times SETS
  always_comb begin
    red = acc;
    if (red >= AW'(4 * SETS)) red = red - AW'(4 * SETS);
    if (red >= AW'(2 * SETS)) red = red - AW'(2 * SETS);
    if (red >= AW'(SETS))     red = red - AW'(SETS);
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd_valid  = 1'b0;
    case (state)
      FR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = FR_HASH;
      end
      FR_HASH: state_next = FR_SUM;
      FR_SUM:  state_next = FR_MOD;
      FR_MOD:  state_next = FR_PUSH;
      FR_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item and advance the reduction one stage a cycle
  always_ff @(posedge clk) begin
    case (state)
      FR_IDLE: begin
        item <= in_m;
        hash <= id_sh ^ key_sh;
      end
      FR_HASH: psum <= psum_next;
      FR_SUM:  acc  <= tot;
      FR_MOD:  rem  <= red[SET_W-1:0];
      default: ;
    endcase
  end

  assign cmd_item = item;
  assign cmd_set  = rem;

endmodule

[hdl/sakvc_queue.sv]
// Two-entry command queue between front and back of the keyed value cache.
// Depends on sakvc_pkg.
module sakvc_queue #(
  parameter int unsigned SET_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  sakvc_pkg::in_item_t wr_item,
  input  logic [SET_W-1:0]    wr_set,
  input  logic                wr_valid,
  output logic                wr_ready,
  output sakvc_pkg::in_item_t rd_item,
  output logic [SET_W-1:0]    rd_set,
  output logic                rd_valid,
  input  logic                rd_ready
);
  import sakvc_pkg::*;

  in_item_t         q_item [2];
  logic [SET_W-1:0] q_set  [2];
  logic             wp, rp;
  logic [1:0]       fill;
  logic             push, pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = q_item[rp];
  assign rd_set   = q_set[rp];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_item[wp] <= wr_item;
      q_set[wp]  <= wr_set;
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) fill <= 2'd2;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_pop_drops;
    @(posedge clk) disable iff (rst) (pop && !push) |=> fill == $past(fill) - 2'd1;
  endproperty
  a_pop_drops: assert property (p_pop_drops) else $error("queue count");

  property p_push_grows;
    @(posedge clk) disable iff (rst) (push && !pop) |=> fill == $past(fill) + 2'd1;
  endproperty
  a_push_grows: assert property (p_push_grows) else $error("queue count");

endmodule

[hdl/sakvc_back.sv]
// Back end of the keyed value cache: holds entry memories, runs operations and sweeps.
// Depends on sakvc_pkg. One memory row per set holds all ways; reset runs a clearing pass.
module sakvc_back #(
  parameter int unsigned WAYS = sakvc_pkg::DefWays,
  parameter int unsigned SETS = sakvc_pkg::DefSets,
  parameter int unsigned KEY_WIDTH = sakvc_pkg::DefKeyWidth,
  parameter int unsigned SET_W = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sakvc_pkg::in_item_t  cmd_item,
  input  logic [SET_W-1:0]     cmd_set,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  output sakvc_pkg::out_item_t out_item,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import sakvc_pkg::*;

  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic [31:0]          id;
    logic [KEY_WIDTH-1:0] key;
    logic [31:0]          value;
    logic [31:0]          age;
    logic [HoldW-1:0]     hold;
  } entry_t;

  typedef entry_t row_t [WAYS];

  row_t             mem [SETS];
  row_t             rd_row, wr_row;
  logic [SET_W-1:0] rd_addr, wr_addr;
  logic             wr_en;

  bk_state_t        state, state_next;
  in_item_t         item;
  logic [SET_W-1:0] set_idx;
  logic [SET_W-1:0] sweep;
  logic [31:0]      age_clock;
  logic             created;
  out_item_t        res;
  logic             init_done;
  logic [KEY_WIDTH-1:0] key_c;

  // Match and victim search over the ways of one row
  logic             hit;
  logic [WW-1:0]    hit_way, vic_way;
  logic [31:0]      best;
  logic [HoldW:0]   hsum;

  assign key_c = KEY_WIDTH'(item.property_key);

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    vic_way = '0;
    best    = 32'hFFFF_FFFF;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && item.object_id != 32'd0 && rd_row[w].id == item.object_id &&
          rd_row[w].key == key_c) begin
        hit     = 1'b1;
        hit_way = WW'(w);
      end
      if (rd_row[w].age <= best) begin
        best    = rd_row[w].age;
        vic_way = WW'(w);
      end
    end
    hsum = {1'b0, rd_row[hit_way].hold} + (HoldW + 1)'(item.pending_invals);
  end

  // Memory row port, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    rd_row <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    out_valid  = 1'b0;
    rd_addr    = set_idx;
    wr_addr    = set_idx;
    wr_en      = 1'b0;
    wr_row     = rd_row;
    case (state)
      BK_IDLE: begin
        if (!init_done) begin
          // Clearing pass after reset, one row a cycle
          wr_addr = sweep;
          wr_en   = 1'b1;
          for (int w = 0; w < WAYS; w++) wr_row[w] = '0;
        end else begin
          cmd_ready = 1'b1;
          if (cmd_valid) state_next = (cmd_item.opcode == OP_WINDOW) ? BK_SWEEP : BK_READ;
        end
      end
      BK_READ: state_next = BK_WAIT;
      BK_WAIT: state_next = BK_EXEC;
      BK_EXEC: begin
        state_next = BK_OUT;
        case (opcode_t'(item.opcode))
          OP_LOOKUP: if (created && hit) begin
            wr_row[hit_way].age = age_clock + 32'd1;
            wr_en = 1'b1;
          end
          OP_STORE: if (item.object_id != 32'd0) begin
            wr_en = 1'b1;
            if (hit) begin
              wr_row[hit_way].value = item.store_value;
              wr_row[hit_way].hold  = hsum[HoldW] ? HoldMax : hsum[HoldW-1:0];
            end else begin
              wr_row[vic_way].id    = item.object_id;
              wr_row[vic_way].key   = key_c;
              wr_row[vic_way].value = item.store_value;
              wr_row[vic_way].age   = age_clock + 32'd1;
              wr_row[vic_way].hold  = HoldW'(item.pending_invals);
            end
          end
          OP_INVAL: if (created && hit) begin
            wr_en = 1'b1;
            if (rd_row[hit_way].hold == '0) begin
              wr_row[hit_way].id    = '0;
              wr_row[hit_way].key   = '0;
              wr_row[hit_way].value = '0;
            end else begin
              wr_row[hit_way].hold = rd_row[hit_way].hold - 1'b1;
            end
          end
          default: ;
        endcase
      end
      BK_SWEEP: begin
        rd_addr = sweep;
        state_next = (created && item.object_id != 32'd0) ? BK_SWEEP_WAIT : BK_OUT;
      end
      BK_SWEEP_WAIT: begin
        rd_addr = sweep;
        state_next = BK_CLEAR;
      end
      BK_CLEAR: begin
        // Clear every way of this row that holds the id
        wr_addr = sweep;
        wr_en   = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
          if (rd_row[w].id == item.object_id) begin
            wr_row[w].id    = '0;
            wr_row[w].key   = '0;
            wr_row[w].value = '0;
          end
        end
        state_next = (sweep == SET_W'(SETS - 1)) ? BK_OUT : BK_SWEEP;
      end
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      sweep     <= '0;
      init_done <= 1'b0;
      age_clock <= '0;
      created   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_IDLE && !init_done) begin
        sweep <= (sweep == SET_W'(SETS - 1)) ? '0 : sweep + 1'b1;
        if (sweep == SET_W'(SETS - 1)) init_done <= 1'b1;
      end
      if (state == BK_CLEAR) begin
        sweep <= (sweep == SET_W'(SETS - 1)) ? '0 : sweep + 1'b1;
      end
      if (state == BK_EXEC) begin
        if (item.opcode == OP_STORE) created <= 1'b1;
        if ((item.opcode == OP_LOOKUP && created && hit) ||
            (item.opcode == OP_STORE && item.object_id != 32'd0 && !hit)) begin
          age_clock <= age_clock + 32'd1;
        end
      end
    end
  end

  // Capture command and build result
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_valid && cmd_ready) begin
      item    <= cmd_item;
      set_idx <= cmd_set;
      res     <= '0;
    end
    if (state == BK_EXEC && item.opcode == OP_LOOKUP) begin
      if (!created) res.status <= ST_NOCACHE;
      else if (hit) res.read_value <= rd_row[hit_way].value;
      else res.status <= ST_MISS;
    end
  end

  assign out_item = res;

  property p_no_cmd_during_init;
    @(posedge clk) disable iff (rst) !init_done |-> !cmd_ready;
  endproperty
  a_no_cmd_during_init: assert property (p_no_cmd_during_init) else $error("cmd during init");

  property p_age_step;
    @(posedge clk) disable iff (rst)
      (state != BK_EXEC) |=> age_clock == $past(age_clock);
  endproperty
  a_age_step: assert property (p_age_step) else $error("age clock moved");

  property p_result_zero;
    @(posedge clk) disable iff (rst)
      (out_valid && res.status != ST_HIT) |-> res.read_value == 32'd0;
  endproperty
  a_result_zero: assert property (p_result_zero) else $error("value on non-hit");

endmodule

[hdl/set_assoc_keyed_value_cache_top.sv]
// Top level of the set-associative keyed value cache.
// Depends on sakvc_pkg, sakvc_front, sakvc_queue and sakvc_back.
//
// Usage: items enter on in_item/in_valid/in_ready and leave one result each
// on out_item/out_valid/out_ready, both valid/ready channels.
// The front works on one item at a time: it accepts it, reduces the set
// hash in its hash, sum and mod states (residue sums, then compare and
// subtract), and hands it off. A two-entry queue decouples it from the
// back, which reads one memory row holding all ways of the set.
// Entry operations pass through the back's accept, read, wait, update and
// result states; the back takes a new command only after its result is
// taken, while the front works on the next item during the back's work.
// Invalidate-window sweeps every set when a store has been made and the id
// is nonzero, reading and clearing each row in turn; else it goes to its result.
// After reset the back clears every row, one per cycle, and accepts no
// command until then. A stalled receiver holds the back in its result
// state; the queue and front then fill and in_ready drops.
module set_assoc_keyed_value_cache_top
  import sakvc_pkg::*;
#(
  parameter int unsigned WAYS      = DefWays,
  parameter int unsigned SETS      = DefSets,
  parameter int unsigned KEY_WIDTH = DefKeyWidth
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      in_valid,
  output logic      in_ready,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int unsigned SET_W = $clog2(SETS);

  in_item_t         f_item, q_item;
  logic [SET_W-1:0] f_set, q_set;
  logic             f_valid, f_ready, q_valid, q_ready;

  sakvc_front #(.SETS(SETS), .KEY_WIDTH(KEY_WIDTH), .SET_W(SET_W)) u_front (
    .clk, .rst, .in_item, .in_valid, .in_ready,
    .cmd_item(f_item), .cmd_set(f_set), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  sakvc_queue #(.SET_W(SET_W)) u_queue (
    .clk, .rst,
    .wr_item(f_item), .wr_set(f_set), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_item(q_item), .rd_set(q_set), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  sakvc_back #(.WAYS(WAYS), .SETS(SETS), .KEY_WIDTH(KEY_WIDTH), .SET_W(SET_W)) u_back (
    .clk, .rst,
    .cmd_item(q_item), .cmd_set(q_set), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .out_item, .out_valid, .out_ready
  );

endmodule
